@@ rtl/simple_rect_region_combine_defines.svh @@
// Assertion macros used by the rectangle combine RTL.
`ifndef SIMPLE_RECT_REGION_COMBINE_DEFINES_SVH
`define SIMPLE_RECT_REGION_COMBINE_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define SRRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define SRRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SRRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/srrc_pkg.sv @@
package srrc_pkg;

    localparam int COORD_W = 28;

    // Combine modes.
    localparam logic [2:0] MODE_AND  = 3'd0;
    localparam logic [2:0] MODE_OR   = 3'd1;
    localparam logic [2:0] MODE_XOR  = 3'd2;
    localparam logic [2:0] MODE_DIFF = 3'd3;
    localparam logic [2:0] MODE_COPY = 3'd4;

    // Source shape codes; any code at or above complex counts as complex.
    localparam logic [1:0] SHAPE_EMPTY   = 2'd0;
    localparam logic [1:0] SHAPE_RECT    = 2'd1;
    localparam logic [1:0] SHAPE_COMPLEX = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_RECT    = 2'd1;
    localparam logic [1:0] ST_GENERAL = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] first_shape;
        t_coord     first_left;
        t_coord     first_top;
        t_coord     first_right;
        t_coord     first_bottom;
        logic [1:0] second_shape;
        t_coord     second_left;
        t_coord     second_top;
        t_coord     second_right;
        t_coord     second_bottom;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_coord     out_left;
        t_coord     out_top;
        t_coord     out_right;
        t_coord     out_bottom;
    } t_rsp;

endpackage

@@ rtl/simple_rect_region_combine.sv @@
// Channel   Direction  Ports                               Payload
// request   in         i_req_valid / o_req_ready           i_req (srrc_pkg::t_req)
// response  out        o_rsp_valid / i_rsp_ready           o_rsp (srrc_pkg::t_rsp)
//
// A request accepted at an edge loads the input register. When the response
// register can load, the compare-and-select result moves into it and is valid
// there until taken. Throughput is one request per cycle while the response
// is not stalled, set by the two-entry register pipeline.
// Reset is synchronous and active low; it clears both valid flags only.
// A stalled response holds the pipeline; the input stage still accepts a new
// request while it is empty or while it can move into the response register.

`include "simple_rect_region_combine_defines.svh"

module simple_rect_region_combine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  srrc_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output srrc_pkg::t_rsp o_rsp
);

    // Pipeline registers. The request register holds the operands and the
    // response register holds the finished result until it is taken.
    logic           r_s1_valid;
    srrc_pkg::t_req r_req;
    logic           r_rsp_valid;
    srrc_pkg::t_rsp r_rsp;
    srrc_pkg::t_rsp n_rsp;

    logic s1_advance;
    logic req_take;

    // The response register can load when it is empty or being drained this
    // cycle. The request register can load when it is empty or its content moves on.
    assign s1_advance  = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = !r_s1_valid || s1_advance;
    assign req_take    = i_req_valid && o_req_ready;

    // Operand aliases. Source one is a, source two is c.
    srrc_pkg::t_coord a_l, a_t, a_r, a_b;
    srrc_pkg::t_coord c_l, c_t, c_r, c_b;
    srrc_pkg::t_coord i_l, i_t, i_r, i_b;
    logic s1_complex, s2_complex;
    logic e1, e2;

    assign a_l = r_req.first_left;
    assign a_t = r_req.first_top;
    assign a_r = r_req.first_right;
    assign a_b = r_req.first_bottom;
    assign c_l = r_req.second_left;
    assign c_t = r_req.second_top;
    assign c_r = r_req.second_right;
    assign c_b = r_req.second_bottom;

    // Shape code three is treated the same as complex.
    assign s1_complex = r_req.first_shape >= srrc_pkg::SHAPE_COMPLEX;
    assign s2_complex = r_req.second_shape >= srrc_pkg::SHAPE_COMPLEX;

    // A rectangle with no area counts as an empty source.
    assign e1 = (r_req.first_shape == srrc_pkg::SHAPE_EMPTY) || (a_l >= a_r) || (a_t >= a_b);
    assign e2 = (r_req.second_shape == srrc_pkg::SHAPE_EMPTY) || (c_l >= c_r) || (c_t >= c_b);

    // Intersection, used by both and and diff.
    assign i_l = (a_l > c_l) ? a_l : c_l;
    assign i_t = (a_t > c_t) ? a_t : c_t;
    assign i_r = (a_r < c_r) ? a_r : c_r;
    assign i_b = (a_b < c_b) ? a_b : c_b;

    // Diff result. The cut keeps one rectangle only when the overlap spans a
    // full extent of source one and touches one of its remaining edges.
    logic [1:0]       diff_st;
    srrc_pkg::t_coord d_l, d_t, d_r, d_b;
    logic             i_empty, i_is_a, d_is_a;

    assign i_empty = (i_l >= i_r) || (i_t >= i_b);
    assign i_is_a  = (i_l == a_l) && (i_t == a_t) && (i_r == a_r) && (i_b == a_b);

    always_comb begin
        d_l = a_l;
        d_t = a_t;
        d_r = a_r;
        d_b = a_b;
        if (i_l == a_l && i_r == a_r) begin
            if (i_t == a_t) begin
                d_t = i_b;
            end else if (i_b == a_b) begin
                d_b = i_t;
            end
        end else if (i_t == a_t && i_b == a_b) begin
            if (i_l == a_l) begin
                d_l = i_r;
            end else if (i_r == a_r) begin
                d_r = i_l;
            end
        end
    end

    assign d_is_a = (d_l == a_l) && (d_t == a_t) && (d_r == a_r) && (d_b == a_b);

    always_comb begin
        if (i_empty) begin
            diff_st = srrc_pkg::ST_RECT;
        end else if (i_is_a) begin
            diff_st = srrc_pkg::ST_EMPTY;
        end else if (d_is_a) begin
            diff_st = srrc_pkg::ST_GENERAL;
        end else begin
            diff_st = srrc_pkg::ST_RECT;
        end
    end

    // Or and xor result. Same x extent merges along y, same y extent along x; or
    // also accepts containment, save a first inside a second with the same left edge.
    logic [1:0]       ox_st;
    srrc_pkg::t_coord x_l, x_t, x_r, x_b;
    logic             is_or;

    assign is_or = (r_req.kind == srrc_pkg::MODE_OR);

    always_comb begin
        x_l   = a_l;
        x_t   = a_t;
        x_r   = a_r;
        x_b   = a_b;
        ox_st = srrc_pkg::ST_GENERAL;
        if (a_l == c_l && a_r == c_r) begin
            if (a_t == c_t && a_b == c_b) begin
                ox_st = is_or ? srrc_pkg::ST_RECT : srrc_pkg::ST_EMPTY;
            end else if (c_b < a_t || c_t > a_b) begin
                ox_st = srrc_pkg::ST_GENERAL;
            end else if (is_or) begin
                x_t   = (a_t < c_t) ? a_t : c_t;
                x_b   = (a_b > c_b) ? a_b : c_b;
                ox_st = srrc_pkg::ST_RECT;
            end else if (c_b == a_t) begin
                x_t   = c_t;
                ox_st = srrc_pkg::ST_RECT;
            end else if (c_t == a_b) begin
                x_b   = c_b;
                ox_st = srrc_pkg::ST_RECT;
            end
        end else if (a_t == c_t && a_b == c_b) begin
            if (c_r < a_l || c_l > a_r) begin
                ox_st = srrc_pkg::ST_GENERAL;
            end else if (is_or) begin
                x_l   = (a_l < c_l) ? a_l : c_l;
                x_r   = (a_r > c_r) ? a_r : c_r;
                ox_st = srrc_pkg::ST_RECT;
            end else if (c_r == a_l) begin
                x_l   = c_l;
                ox_st = srrc_pkg::ST_RECT;
            end else if (c_l == a_r) begin
                x_r   = c_r;
                ox_st = srrc_pkg::ST_RECT;
            end
        end else if (is_or) begin
            if (a_l <= c_l) begin
                if (a_r >= c_r && a_t <= c_t && a_b >= c_b) begin
                    ox_st = srrc_pkg::ST_RECT;
                end
            end else if (c_r >= a_r && c_t <= a_t && c_b >= a_b) begin
                x_l   = c_l;
                x_t   = c_t;
                x_r   = c_r;
                x_b   = c_b;
                ox_st = srrc_pkg::ST_RECT;
            end
        end
    end

    // Final selection by mode and source shapes.
    logic [1:0]       sel_st;
    srrc_pkg::t_coord s_l, s_t, s_r, s_b;

    always_comb begin
        sel_st = srrc_pkg::ST_EMPTY;
        s_l    = a_l;
        s_t    = a_t;
        s_r    = a_r;
        s_b    = a_b;
        if (r_req.kind > srrc_pkg::MODE_COPY) begin
            sel_st = srrc_pkg::ST_INVALID;
        end else if (s1_complex) begin
            sel_st = srrc_pkg::ST_GENERAL;
        end else if (r_req.kind == srrc_pkg::MODE_COPY) begin
            sel_st = e1 ? srrc_pkg::ST_EMPTY : srrc_pkg::ST_RECT;
        end else if (s2_complex) begin
            sel_st = srrc_pkg::ST_GENERAL;
        end else begin
            case (r_req.kind)
                srrc_pkg::MODE_AND: begin
                    sel_st = (e1 || e2) ? srrc_pkg::ST_EMPTY : srrc_pkg::ST_RECT;
                    s_l    = i_l;
                    s_t    = i_t;
                    s_r    = i_r;
                    s_b    = i_b;
                end
                srrc_pkg::MODE_DIFF: begin
                    // A second source that misses the first leaves it whole.
                    if (e1) begin
                        sel_st = srrc_pkg::ST_EMPTY;
                    end else if (e2 || i_empty) begin
                        sel_st = srrc_pkg::ST_RECT;
                    end else begin
                        sel_st = diff_st;
                        s_l    = d_l;
                        s_t    = d_t;
                        s_r    = d_r;
                        s_b    = d_b;
                    end
                end
                default: begin
                    // Or and xor.
                    if (e1) begin
                        sel_st = e2 ? srrc_pkg::ST_EMPTY : srrc_pkg::ST_RECT;
                        s_l    = c_l;
                        s_t    = c_t;
                        s_r    = c_r;
                        s_b    = c_b;
                    end else if (e2) begin
                        sel_st = srrc_pkg::ST_RECT;
                    end else begin
                        sel_st = ox_st;
                        s_l    = x_l;
                        s_t    = x_t;
                        s_r    = x_r;
                        s_b    = x_b;
                    end
                end
            endcase
        end
    end

    // A single rectangle with no area is reported as empty, and every
    // coordinate is zero unless the result is a single rectangle.
    logic sel_degenerate;

    assign sel_degenerate = (s_l >= s_r) || (s_t >= s_b);

    always_comb begin
        n_rsp = '0;
        if (sel_st == srrc_pkg::ST_RECT) begin
            if (sel_degenerate) begin
                n_rsp.status = srrc_pkg::ST_EMPTY;
            end else begin
                n_rsp.status     = srrc_pkg::ST_RECT;
                n_rsp.out_left   = s_l;
                n_rsp.out_top    = s_t;
                n_rsp.out_right  = s_r;
                n_rsp.out_bottom = s_b;
            end
        end else begin
            n_rsp.status = sel_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_s1_valid <= i_req_valid;
            end
            if (s1_advance) begin
                r_rsp_valid <= r_s1_valid;
            end
        end
        if (req_take) begin
            r_req <= i_req;
        end
        if (s1_advance && r_s1_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // A request waiting in the input register survives a stalled response.
    `SRRC_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && r_rsp_valid && !i_rsp_ready, r_s1_valid, "request lost while response stalled")
    // Coordinates are zero whenever the response is not a single rectangle.
    `SRRC_ASSERT_SAME(a_zero_coords, i_clk, i_rst_n, r_rsp_valid && (r_rsp.status != srrc_pkg::ST_RECT), (r_rsp.out_left == '0) && (r_rsp.out_top == '0) && (r_rsp.out_right == '0) && (r_rsp.out_bottom == '0), "nonzero coordinates on non-rectangle result")
    // An invalid mode moving into the response register reports invalid.
    `SRRC_ASSERT_NEXT(a_invalid_mode, i_clk, i_rst_n, r_s1_valid && s1_advance && (r_req.kind > srrc_pkg::MODE_COPY), r_rsp_valid && (r_rsp.status == srrc_pkg::ST_INVALID), "invalid mode not reported")

endmodule

@@ tb/sv/region_combine_checker.sv @@
module region_combine_checker
    import srrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    // Unpacked so that every edge keeps its signed coordinate type.
    typedef struct {
        t_coord l;
        t_coord t;
        t_coord r;
        t_coord b;
    } t_box;

    t_rsp predicted_regions[$];
    t_rsp oldest;
    int   mismatches = 0;

    function automatic logic is_void(t_box x);
        return (x.l >= x.r) || (x.t >= x.b);
    endfunction

    function automatic logic same_box(t_box x, t_box y);
        return (x.l == y.l) && (x.t == y.t) && (x.r == y.r) && (x.b == y.b);
    endfunction

    function automatic t_coord min_c(t_coord x, t_coord y);
        return (x < y) ? x : y;
    endfunction

    function automatic t_coord max_c(t_coord x, t_coord y);
        return (x > y) ? x : y;
    endfunction

    function automatic t_rsp combine_regions(t_req q);
        t_box       a;
        t_box       c;
        t_box       cut;
        t_box       o;
        logic [1:0] st;
        logic       a_none;
        logic       c_none;
        logic       is_or;
        t_rsp       res;
        a = '{q.first_left, q.first_top, q.first_right, q.first_bottom};
        c = '{q.second_left, q.second_top, q.second_right, q.second_bottom};
        cut = '{max_c(a.l, c.l), max_c(a.t, c.t), min_c(a.r, c.r), min_c(a.b, c.b)};
        a_none = (q.first_shape == SHAPE_EMPTY) || is_void(a);
        c_none = (q.second_shape == SHAPE_EMPTY) || is_void(c);
        is_or = (q.kind == MODE_OR);
        o = a;
        st = ST_GENERAL;
        if (q.kind > MODE_COPY) begin
            st = ST_INVALID;
        end else if (q.first_shape >= SHAPE_COMPLEX) begin
            st = ST_GENERAL;
        end else if (q.kind == MODE_COPY) begin
            st = a_none ? ST_EMPTY : ST_RECT;
        end else if (q.second_shape >= SHAPE_COMPLEX) begin
            st = ST_GENERAL;
        end else if (q.kind == MODE_AND) begin
            if (a_none || c_none) begin
                st = ST_EMPTY;
            end else begin
                o = cut;
                st = ST_RECT;
            end
        end else if (q.kind == MODE_DIFF) begin
            if (a_none) begin
                st = ST_EMPTY;
            end else if (c_none || is_void(cut)) begin
                st = ST_RECT;
            end else if (same_box(cut, a)) begin
                st = ST_EMPTY;
            end else begin
                // Only a full-width or full-height strip off one side trims cleanly.
                if (cut.l == a.l && cut.r == a.r) begin
                    if (cut.t == a.t) o.t = cut.b;
                    else if (cut.b == a.b) o.b = cut.t;
                end else if (cut.t == a.t && cut.b == a.b) begin
                    if (cut.l == a.l) o.l = cut.r;
                    else if (cut.r == a.r) o.r = cut.l;
                end
                st = same_box(o, a) ? ST_GENERAL : ST_RECT;
            end
        end else if (a_none) begin
            if (c_none) begin
                st = ST_EMPTY;
            end else begin
                o = c;
                st = ST_RECT;
            end
        end else if (c_none) begin
            st = ST_RECT;
        end else if (a.l == c.l && a.r == c.r) begin
            if (a.t == c.t && a.b == c.b) begin
                st = is_or ? ST_RECT : ST_EMPTY;
            end else if (c.b < a.t || c.t > a.b) begin
                st = ST_GENERAL;
            end else if (is_or) begin
                o.t = min_c(a.t, c.t);
                o.b = max_c(a.b, c.b);
                st = ST_RECT;
            end else if (c.b == a.t) begin
                o.t = c.t;
                st = ST_RECT;
            end else if (c.t == a.b) begin
                o.b = c.b;
                st = ST_RECT;
            end
        end else if (a.t == c.t && a.b == c.b) begin
            if (c.r < a.l || c.l > a.r) begin
                st = ST_GENERAL;
            end else if (is_or) begin
                o.l = min_c(a.l, c.l);
                o.r = max_c(a.r, c.r);
                st = ST_RECT;
            end else if (c.r == a.l) begin
                o.l = c.l;
                st = ST_RECT;
            end else if (c.l == a.r) begin
                o.r = c.r;
                st = ST_RECT;
            end
        end else if (is_or && a.l <= c.l && a.r >= c.r && a.t <= c.t && a.b >= c.b) begin
            st = ST_RECT;
        end else if (is_or && a.l > c.l && c.r >= a.r && c.t <= a.t && c.b >= a.b) begin
            o = c;
            st = ST_RECT;
        end
        if (st == ST_RECT && is_void(o)) st = ST_EMPTY;
        res = '0;
        res.status = st;
        if (st == ST_RECT) begin
            res.out_left   = o.l;
            res.out_top    = o.t;
            res.out_right  = o.r;
            res.out_bottom = o.b;
        end
        return res;
    endfunction

    task automatic check_field(string name, t_coord want, t_coord got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Responses are retired before the same edge's request is queued.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (predicted_regions.size() == 0) begin
                    $error("response with no request outstanding: status %0d", i_rsp.status);
                    mismatches++;
                end else begin
                    oldest = predicted_regions.pop_front();
                    check_field("status", t_coord'(oldest.status), t_coord'(i_rsp.status));
                    check_field("out_left", oldest.out_left, i_rsp.out_left);
                    check_field("out_top", oldest.out_top, i_rsp.out_top);
                    check_field("out_right", oldest.out_right, i_rsp.out_right);
                    check_field("out_bottom", oldest.out_bottom, i_rsp.out_bottom);
                end
            end
            if (i_req_valid && i_req_ready) predicted_regions.push_back(combine_regions(i_req));
        end
        o_pending    <= predicted_regions.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the rectangle combine bench. This module only makes stimulus, shapes
// the flow on both channels and gives the verdict; all prediction and
// comparison lives in the checker that sits beside the block.
module testbench;
    import srrc_pkg::*;

    // Extremes of the 28-bit signed coordinate range.
    localparam int COORD_MIN = -(1 << 27);
    localparam int COORD_MAX = (1 << 27) - 1;

    // Mode codes above copy are reserved, and the spare shape code is
    // handled as complex by the block.
    localparam logic [2:0] MODE_FIRST_RESERVED = 3'd5;
    localparam logic [1:0] SHAPE_SPARE         = 2'd3;

    localparam int RANDOM_ITEMS = 750;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 120;
    localparam int HOLD_EVERY   = 250;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    t_req req       = '0;
    logic rsp_ready = 1'b0;
    logic req_ready;
    logic rsp_valid;
    t_rsp rsp;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    simple_rect_region_combine DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    region_combine_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The watchdog ends a run in which neither channel has moved for a long
    // while; the longest legal quiet stretch is the receiver's long hold.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Gap lengths for both sides, drawn from a short, a medium and a long band
    // with falling odds.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(3, 1);
        if (roll < 95) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Coordinates cluster near zero so that edges often coincide or abut,
    // with the range ends and fully random values mixed in.
    function automatic int pick_coord();
        int roll;
        roll = $urandom_range(19);
        if (roll < 4) return int'($urandom);
        if (roll == 4) return COORD_MIN;
        if (roll == 5) return COORD_MAX;
        return int'($urandom_range(16)) - 8;
    endfunction

    // Width or height of a rectangle; zero and negative sizes give
    // degenerate sources.
    function automatic int pick_size();
        int roll;
        roll = $urandom_range(19);
        if (roll < 2) return 0;
        if (roll == 2) return -int'($urandom_range(3, 1));
        return int'($urandom_range(6, 1));
    endfunction

    function automatic int nudge();
        return int'($urandom_range(4)) - 2;
    endfunction

    function automatic logic [1:0] pick_shape();
        int roll;
        roll = $urandom_range(19);
        if (roll < 16) return SHAPE_RECT;
        if (roll < 18) return SHAPE_EMPTY;
        if (roll == 18) return SHAPE_COMPLEX;
        return SHAPE_SPARE;
    endfunction

    function automatic t_req build_req(logic [2:0] kind, logic [1:0] s1,
                                       int al, int at, int ar, int ab,
                                       logic [1:0] s2,
                                       int cl, int ct, int cr, int cb);
        t_req q;
        q.kind          = kind;
        q.first_shape   = s1;
        q.first_left    = t_coord'(al);
        q.first_top     = t_coord'(at);
        q.first_right   = t_coord'(ar);
        q.first_bottom  = t_coord'(ab);
        q.second_shape  = s2;
        q.second_left   = t_coord'(cl);
        q.second_top    = t_coord'(ct);
        q.second_right  = t_coord'(cr);
        q.second_bottom = t_coord'(cb);
        return q;
    endfunction

    // Most random requests place the second rectangle in a deliberate
    // relation to the first (identical, sharing an extent and touching,
    // nested, or with edges nudged), since independent rectangles almost
    // always end on the general path.
    function automatic t_req random_request();
        logic [2:0] kind;
        int         al;
        int         at;
        int         ar;
        int         ab;
        int         cl;
        int         ct;
        int         cr;
        int         cb;
        int         dir;
        if ($urandom_range(99) < 12) kind = MODE_FIRST_RESERVED + 3'($urandom_range(2));
        else kind = 3'($urandom_range(MODE_COPY));
        al = pick_coord();
        at = pick_coord();
        ar = al + pick_size();
        ab = at + pick_size();
        case ($urandom_range(5))
            0: begin
                cl = pick_coord();
                ct = pick_coord();
                cr = cl + pick_size();
                cb = ct + pick_size();
            end
            1: begin
                cl = al;
                ct = at;
                cr = ar;
                cb = ab;
            end
            2: begin
                cl = al;
                cr = ar;
                if ($urandom_range(1)) begin
                    cb = at + nudge();
                    ct = cb - pick_size();
                end else begin
                    ct = ab + nudge();
                    cb = ct + pick_size();
                end
            end
            3: begin
                ct = at;
                cb = ab;
                if ($urandom_range(1)) begin
                    cr = al + nudge();
                    cl = cr - pick_size();
                end else begin
                    cl = ar + nudge();
                    cr = cl + pick_size();
                end
            end
            4: begin
                dir = $urandom_range(1) ? 1 : -1;
                cl = al - dir * int'($urandom_range(2));
                ct = at - dir * int'($urandom_range(2));
                cr = ar + dir * int'($urandom_range(2));
                cb = ab + dir * int'($urandom_range(2));
            end
            default: begin
                cl = al + nudge();
                ct = at + nudge();
                cr = ar + nudge();
                cb = ab + nudge();
            end
        endcase
        return build_req(kind, pick_shape(), al, at, ar, ab, pick_shape(), cl, ct, cr, cb);
    endfunction

    // Offers one request, after an optional gap, and returns at the edge on
    // which the block takes it. Valid stays high into the next request when
    // there is no gap.
    task automatic push_request(t_req item, int gap_pct);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stops offering and waits until every predicted response has arrived.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Receiving side. It stalls at random with a rate that is redrawn during
    // the run, so some stretches run with no stalls at all. Twice during
    // the run it holds off for a long stretch while the sender keeps
    // offering, which fills the block and pushes back on the request side.
    initial begin : rsp_side
        int taken;
        int stall_left;
        int stall_pct;
        int cycle;
        int holds_done;
        taken      = 0;
        stall_left = 0;
        stall_pct  = 15;
        cycle      = 0;
        holds_done = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (rsp_valid && rsp_ready) taken++;
            cycle++;
            if (cycle % 64 == 0) begin
                case ($urandom_range(2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 50;
                endcase
            end
            if (holds_done < 2 && taken >= HOLD_EVERY * (holds_done + 1)) begin
                holds_done++;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end else if ($urandom_range(99) < stall_pct) begin
                stall_left = pick_gap() - 1;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Sending side: a directed list first, then random requests. The run
    // drains completely after the directed part and again halfway through
    // the random part.
    initial begin : stimulus
        t_req directed[$];
        int   gap_pct;
        gap_pct = 0;

        // Reserved modes, whatever the sources hold.
        directed.push_back(build_req(MODE_FIRST_RESERVED, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, 0, 0, 4, 4));
        directed.push_back(build_req(MODE_FIRST_RESERVED + 3'd1, SHAPE_COMPLEX, 1, 1, 3, 3,
                                     SHAPE_SPARE, 0, 0, 2, 2));
        directed.push_back(build_req(MODE_FIRST_RESERVED + 3'd2, SHAPE_EMPTY, 0, 0, 0, 0,
                                     SHAPE_EMPTY, 0, 0, 0, 0));
        // Copy ignores the second source, even a complex one; an empty or
        // degenerate first source copies as empty.
        directed.push_back(build_req(MODE_COPY, SHAPE_RECT, 1, 2, 5, 6,
                                     SHAPE_COMPLEX, 0, 0, 9, 9));
        directed.push_back(build_req(MODE_COPY, SHAPE_EMPTY, 1, 2, 5, 6,
                                     SHAPE_RECT, 0, 0, 9, 9));
        directed.push_back(build_req(MODE_COPY, SHAPE_RECT, 5, 0, 5, 4,
                                     SHAPE_RECT, 0, 0, 9, 9));
        directed.push_back(build_req(MODE_COPY, SHAPE_RECT, COORD_MIN, COORD_MIN,
                                     COORD_MAX, COORD_MAX,
                                     SHAPE_SPARE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        // Complex first source, and the spare shape code on the second.
        directed.push_back(build_req(MODE_AND, SHAPE_COMPLEX, 0, 0, 4, 4,
                                     SHAPE_RECT, 0, 0, 4, 4));
        directed.push_back(build_req(MODE_OR, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_SPARE, 0, 0, 4, 4));
        // Intersection: overlap, disjoint (no area left), and empty second.
        directed.push_back(build_req(MODE_AND, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, 2, 2, 6, 6));
        directed.push_back(build_req(MODE_AND, SHAPE_RECT, 0, 0, 2, 2,
                                     SHAPE_RECT, 3, 3, 5, 5));
        directed.push_back(build_req(MODE_AND, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_EMPTY, 0, 0, 4, 4));
        // Union: stacked strips, nesting, an L shape, and empty first.
        directed.push_back(build_req(MODE_OR, SHAPE_RECT, 0, 0, 4, 2,
                                     SHAPE_RECT, 0, 2, 4, 5));
        directed.push_back(build_req(MODE_OR, SHAPE_RECT, 0, 0, 8, 8,
                                     SHAPE_RECT, 2, 2, 4, 4));
        directed.push_back(build_req(MODE_OR, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, 2, 2, 6, 6));
        directed.push_back(build_req(MODE_OR, SHAPE_EMPTY, 0, 0, 4, 4,
                                     SHAPE_RECT, -3, -2, 1, 7));
        // Exclusive or: equal boxes, side-by-side boxes, overlapping strips.
        directed.push_back(build_req(MODE_XOR, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, 0, 0, 4, 4));
        directed.push_back(build_req(MODE_XOR, SHAPE_RECT, 0, 0, 2, 4,
                                     SHAPE_RECT, 2, 0, 5, 4));
        directed.push_back(build_req(MODE_XOR, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, 0, 2, 4, 6));
        // Difference: a strip off the top, a hole, full cover, no overlap.
        directed.push_back(build_req(MODE_DIFF, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, 0, -1, 4, 2));
        directed.push_back(build_req(MODE_DIFF, SHAPE_RECT, 0, 0, 8, 8,
                                     SHAPE_RECT, 2, 2, 4, 4));
        directed.push_back(build_req(MODE_DIFF, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, -1, -1, 5, 5));
        directed.push_back(build_req(MODE_DIFF, SHAPE_RECT, 0, 0, 4, 4,
                                     SHAPE_RECT, 6, 6, 9, 9));
        // Union of two full-width strips at the coordinate extremes.
        directed.push_back(build_req(MODE_OR, SHAPE_RECT, COORD_MIN, 0, COORD_MAX, 4,
                                     SHAPE_RECT, COORD_MIN, 4, COORD_MAX, 8));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[n]) push_request(directed[n], 30);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // The sender's gap rate changes every 50 requests, so some
            // stretches are offered back to back.
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
            end
            if (n == RANDOM_ITEMS / 2) wait_drained();
            push_request(random_request(), gap_pct);
        end

        // Let the two-stage pipeline empty, then keep watching the outputs to catch
        // any stray response.
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/srrc_pkg.sv
rtl/simple_rect_region_combine.sv
tb/sv/region_combine_checker.sv
tb/sv/testbench.sv
